@@ design/assert_macros.svh @@
// assertion macros shared by the insertion sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ISORT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ISORT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/isort_pkg.sv @@
// shared constants and types of the insertion sorter
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned VALUE_W  = 31;

  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_KEY,
    S_KEYW,
    S_CMP,
    S_PUT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

endpackage

`default_nettype wire

@@ design/isort_if.sv @@
// valid/ready channel interfaces for list input and sorted output
`timescale 1ns / 1ps
`default_nettype none

interface isort_in_if;
  logic                  valid;
  logic                  ready;
  isort_pkg::value_t     element_value;
  logic                  is_final;

  modport source (output valid, output element_value, output is_final, input ready);
  modport sink   (input valid, input element_value, input is_final, output ready);
endinterface

interface isort_out_if;
  logic                  valid;
  logic                  ready;
  isort_pkg::value_t     sorted_value;
  logic                  is_last_out;
  logic                  overflowed;

  modport source (output valid, output sorted_value, output is_last_out,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input is_last_out,
                  input overflowed, output ready);
endinterface

`default_nettype wire

@@ design/isort_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module isort_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/insertion_sorter_top.sv @@
// sorting reads each element as the key, then compares it with and shifts the entries before it
// (one ram read or compare-and-shift per cycle on the single element ram)
// emission reads each result from the ram, then loads it into the output register once that is free
// one list is handled at a time; input is taken again once the last result is registered
// rst_ni clears count, overflow flag, fsm and output valid; sort order resets to ascending
// ram contents are not cleared; every entry whose read data is used was written by the current list
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module insertion_sorter_top #(
  parameter int unsigned CAPACITY = isort_pkg::CAPACITY
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  isort_in_if.sink    in_i,
  isort_out_if.source out_o,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  isort_pkg::state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     k_q, k_d;
  isort_pkg::value_t key_q, key_d;
  logic              asc_q;

  logic              out_valid_q;
  isort_pkg::value_t out_value_q;
  logic              out_last_q;
  logic              out_ovf_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  isort_pkg::value_t ram_wdata;
  logic [AW-1:0]     ram_raddr;
  isort_pkg::value_t ram_rdata;

  logic in_ready;
  logic in_fire;
  logic full;
  logic out_free;
  logic out_load;
  logic move;
  logic key_last;
  logic emit_last;

  logic cmp_st;
  logic emit_st;
  logic run_done;
  logic idle_clear;
  logic reset_idle;

  assign in_fire   = in_i.valid && in_ready;
  assign full      = (cnt_q == CW'(CAPACITY));
  assign out_free  = !out_valid_q || out_o.ready;
  // previous entry must shift right past the key; equal keys stay put
  assign move      = asc_q ? (ram_rdata > key_q) : (ram_rdata < key_q);
  assign key_last  = ((idx_q + CW'(1)) == cnt_q);
  assign emit_last = ((k_q + CW'(1)) == cnt_q);

  isort_ram #(
    .WIDTH (isort_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      isort_pkg::S_LOAD: begin
        if (in_fire && in_i.is_final) begin
          // a single element list needs no sort
          state_d = (cnt_q == '0) ? isort_pkg::S_EMIT_RD : isort_pkg::S_KEY;
        end
      end
      isort_pkg::S_KEY:  state_d = isort_pkg::S_KEYW;
      isort_pkg::S_KEYW: state_d = isort_pkg::S_CMP;
      isort_pkg::S_CMP: begin
        if (move) begin
          state_d = (pos_q == AW'(1)) ? isort_pkg::S_PUT : isort_pkg::S_CMP;
        end else begin
          state_d = key_last ? isort_pkg::S_EMIT_RD : isort_pkg::S_KEY;
        end
      end
      isort_pkg::S_PUT: begin
        state_d = key_last ? isort_pkg::S_EMIT_RD : isort_pkg::S_KEY;
      end
      isort_pkg::S_EMIT_RD: state_d = isort_pkg::S_EMIT_LD;
      isort_pkg::S_EMIT_LD: begin
        if (out_free) begin
          state_d = emit_last ? isort_pkg::S_LOAD : isort_pkg::S_EMIT_RD;
        end
      end
      default: state_d = isort_pkg::S_LOAD;
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q;
    ram_raddr = k_q[AW-1:0];
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      isort_pkg::S_LOAD: begin
        in_ready  = 1'b1;
        ram_we    = in_fire && !full;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = in_i.element_value;
      end
      isort_pkg::S_KEY: begin
        ram_raddr = idx_q[AW-1:0];
      end
      isort_pkg::S_KEYW: begin
        ram_raddr = idx_q[AW-1:0] - AW'(1);
      end
      isort_pkg::S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        if (move) begin
          ram_wdata = ram_rdata;
          ram_raddr = pos_q - AW'(2);
        end
      end
      isort_pkg::S_PUT: begin
        ram_we = 1'b1;
      end
      isort_pkg::S_EMIT_RD: begin
        ram_raddr = k_q[AW-1:0];
      end
      isort_pkg::S_EMIT_LD: begin
        // hold the address so read data stays put while the output stalls
        ram_raddr = k_q[AW-1:0];
        out_load  = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    idx_d = idx_q;
    pos_d = pos_q;
    k_d   = k_q;
    key_d = key_q;
    case (state_q)
      isort_pkg::S_LOAD: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
          if (in_i.is_final) begin
            idx_d = CW'(1);
            k_d   = '0;
          end
        end
      end
      isort_pkg::S_KEYW: begin
        key_d = ram_rdata;
        pos_d = idx_q[AW-1:0];
      end
      isort_pkg::S_CMP: begin
        if (move) begin
          pos_d = pos_q - AW'(1);
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      isort_pkg::S_PUT: begin
        idx_d = idx_q + CW'(1);
      end
      isort_pkg::S_EMIT_LD: begin
        if (out_free) begin
          k_d = k_q + CW'(1);
          if (emit_last) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isort_pkg::S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      asc_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        asc_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_load) begin
      out_value_q <= ram_rdata;
      out_last_q  <= emit_last;
      out_ovf_q   <= ovf_q;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.is_last_out  = out_last_q;
  assign out_o.overflowed   = out_ovf_q;

  assign cmp_st     = (state_q == isort_pkg::S_CMP);
  assign emit_st    = (state_q == isort_pkg::S_EMIT_RD) || (state_q == isort_pkg::S_EMIT_LD);
  assign run_done   = out_load && emit_last;
  assign idle_clear = (cnt_q == '0) && !ovf_q && (state_q == isort_pkg::S_LOAD);
  assign reset_idle = (state_q == isort_pkg::S_LOAD) && !out_valid_q;

  `ISORT_ASSERT(a_cnt_in_range, cnt_q <= CW'(CAPACITY), "element count above capacity")
  `ISORT_ASSERT(a_pos_below_key, cmp_st |-> (CW'(pos_q) <= idx_q), "insert position past key")
  `ISORT_ASSERT(a_no_write_in_emit, emit_st |-> !ram_we, "ram written during emission")
  `ISORT_ASSERT(a_run_done_clears, run_done |=> idle_clear, "list state not cleared after run")
  `ISORT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> reset_idle, "not idle after reset edge")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for insertion_sorter_top: loads lists, predicts sorted runs
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned MAX_SHOWN    = 10;

  typedef struct {
    isort_pkg::value_t elem;
    logic              fin;
  } list_item_t;

  typedef struct {
    isort_pkg::value_t elem;
    logic              last;
    logic              ovf;
  } sorted_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  isort_in_if  list_in ();
  isort_out_if sorted_out ();

  insertion_sorter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (list_in),
    .out_o      (sorted_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  list_item_t  pending_items [$];
  sorted_rec_t sorted_expect [$];

  // predictor state
  isort_pkg::value_t held_elems [isort_pkg::CAPACITY];
  int unsigned       held_count;
  logic              held_ovf;
  logic              order_asc;

  // run control and statistics
  logic        steady;
  logic        hold_armed;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned lists_sorted;
  int unsigned lists_desc;
  int unsigned lists_ovf;
  int unsigned longest_list;

  // takes one accepted element and, on the final one, queues the sorted run
  task automatic load_element(input isort_pkg::value_t v, input logic fin);
    isort_pkg::value_t run [isort_pkg::CAPACITY];
    isort_pkg::value_t key;
    int unsigned       n;
    int unsigned       pos;
    sorted_rec_t       rec;
    if (held_count < isort_pkg::CAPACITY) begin
      held_elems[held_count] = v;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (fin) begin
      n   = held_count;
      run = held_elems;
      // stable: only strictly out-of-order neighbors move
      for (int unsigned i = 1; i < n; i++) begin
        key = run[i];
        pos = i;
        while (pos > 0 && (order_asc ? (run[pos-1] > key) : (run[pos-1] < key))) begin
          run[pos] = run[pos-1];
          pos--;
        end
        run[pos] = key;
      end
      for (int unsigned k = 0; k < n; k++) begin
        rec.elem = run[k];
        rec.last = (k + 1 == n);
        rec.ovf  = held_ovf;
        sorted_expect.push_back(rec);
      end
      lists_sorted++;
      if (!order_asc) lists_desc++;
      if (held_ovf) lists_ovf++;
      if (n > longest_list) longest_list = n;
      held_count = 0;
      held_ovf   = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string what, input sorted_rec_t want,
                               input sorted_rec_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN)
      $display("%0t: %s: expected value %h last %b ovf %b, got value %h last %b ovf %b",
               $time, what, want.elem, want.last, want.ovf, got.elem, got.last, got.ovf);
  endtask

  task automatic check_result(input sorted_rec_t got);
    sorted_rec_t want;
    results_seen++;
    if (sorted_expect.size() == 0) begin
      want = '{elem: '0, last: 1'b0, ovf: 1'b0};
      note_mismatch("result with nothing outstanding", want, got);
    end else begin
      want = sorted_expect.pop_front();
      if (got.elem !== want.elem || got.last !== want.last || got.ovf !== want.ovf)
        note_mismatch("sorted result mismatch", want, got);
    end
  endtask

  // sender: offers the oldest pending element, holds it until the transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_in.valid         <= 1'b0;
      list_in.element_value <= '0;
      list_in.is_final      <= 1'b0;
    end else begin
      if (list_in.valid && list_in.ready) begin
        load_element(list_in.element_value, list_in.is_final);
        void'(pending_items.pop_front());
        items_taken++;
      end
      if (list_in.valid && !list_in.ready) begin
        // keep offering the same element
      end else if (pending_items.size() != 0 &&
                   (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        list_in.valid         <= 1'b1;
        list_in.element_value <= pending_items[0].elem;
        list_in.is_final      <= pending_items[0].fin;
      end else begin
        list_in.valid <= 1'b0;
      end
    end
  end

  // receiver: checks each transfer, stalls at random and once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_out.ready <= 1'b0;
      hold_left        <= 0;
      hold_done        <= 1'b0;
    end else begin
      if (sorted_out.valid && sorted_out.ready)
        check_result('{elem: sorted_out.sorted_value, last: sorted_out.is_last_out,
                       ovf: sorted_out.overflowed});
      if (hold_armed && !hold_done && sorted_out.valid) begin
        hold_done        <= 1'b1;
        hold_left        <= HOLD_CYCLES;
        sorted_out.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left        <= hold_left - 1;
        sorted_out.ready <= 1'b0;
      end else begin
        sorted_out.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, sorted_expect.size());
      $display("insertion_sorter_top test failed");
      $finish;
    end
  end

  function automatic isort_pkg::value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return isort_pkg::value_t'($urandom_range(0, 7));
      3:       return isort_pkg::value_t'(32'h7FFF_FFF8 + $urandom_range(0, 6));
      default: return isort_pkg::value_t'($urandom());
    endcase
  endfunction

  task automatic queue_item(input isort_pkg::value_t v, input logic fin);
    pending_items.push_back('{elem: v, fin: fin});
  endtask

  task automatic queue_list(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) queue_item(pick_value(), i + 1 == len);
  endtask

  task automatic set_order(input logic asc);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= asc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    order_asc = asc;
    @(negedge clk_i);
  endtask

  // the main sequence waits here until every run of the phase has come back
  task automatic drain_phase();
    while (pending_items.size() != 0 || sorted_expect.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned len;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = 1'b0;
    list_in.valid         = 1'b0;
    list_in.element_value = '0;
    list_in.is_final      = 1'b0;
    sorted_out.ready      = 1'b0;
    held_count            = 0;
    held_ovf              = 1'b0;
    order_asc             = 1'b1;
    steady                = 1'b0;
    hold_armed            = 1'b0;
    cycle_cnt             = 0;
    mismatch_cnt          = 0;
    items_taken           = 0;
    results_seen          = 0;
    lists_sorted          = 0;
    lists_desc            = 0;
    lists_ovf             = 0;
    longest_list          = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, ascending: single elements at both extremes, duplicates
    set_order(1'b1);
    queue_item('0, 1'b1);
    queue_item('1, 1'b1);
    queue_item(isort_pkg::value_t'(5), 1'b0);
    queue_item('0, 1'b0);
    queue_item('1, 1'b0);
    queue_item(isort_pkg::value_t'(5), 1'b0);
    queue_item(isort_pkg::value_t'(32'h4000_0000), 1'b0);
    queue_item(isort_pkg::value_t'(32'h7FFF_FFFE), 1'b0);
    queue_item(isort_pkg::value_t'(1), 1'b1);
    drain_phase();

    // directed, descending: alternating bit patterns, equal keys, one and two element lists
    set_order(1'b0);
    queue_item(isort_pkg::value_t'(32'h2AAA_AAAA), 1'b0);
    queue_item(isort_pkg::value_t'(32'h5555_5555), 1'b0);
    queue_item(isort_pkg::value_t'(3), 1'b0);
    queue_item('1, 1'b0);
    queue_item('0, 1'b0);
    queue_item(isort_pkg::value_t'(3), 1'b1);
    queue_item(isort_pkg::value_t'(7), 1'b1);
    queue_item('0, 1'b0);
    queue_item('1, 1'b1);
    drain_phase();

    // random phases, alternating sort order
    for (int unsigned ph = 0; ph < 6; ph++) begin
      set_order(ph[0]);
      hold_armed = (ph == 0);
      steady     = (ph == 1);
      phase_items = 0;
      // a full store, then one that drops elements including the final one
      if (ph == 2) begin
        queue_list(isort_pkg::CAPACITY);
        phase_items += isort_pkg::CAPACITY;
      end
      if (ph == 3) begin
        queue_list(isort_pkg::CAPACITY + 2);
        phase_items += isort_pkg::CAPACITY + 2;
      end
      while (phase_items < 25 + ((ph >= 2 && ph <= 3) ? isort_pkg::CAPACITY : 0)) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        queue_list(len);
        phase_items += len;
      end
      drain_phase();
      steady = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sorted_expect.size() != 0) mismatch_cnt += sorted_expect.size();

    $display("loaded %0d elements into %0d lists (%0d descending, %0d overflowed, longest %0d)",
             items_taken, lists_sorted, lists_desc, lists_ovf, longest_list);
    $display("checked %0d sorted results, %0d mismatches", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("insertion_sorter_top test passed");
    end else begin
      $display("insertion_sorter_top test failed");
    end
    $finish;
  end

endmodule
